>>> hdl/glyph_pixel_renderer_top_macros.svh
// Assertion macros for the glyph pixel renderer RTL, used by the back end.
`ifndef GLYPH_PIXEL_RENDERER_TOP_MACROS_SVH
`define GLYPH_PIXEL_RENDERER_TOP_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk_i, off during reset.
`define GPR_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, sampled on clk_i, off during reset.
`define GPR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define GPR_ASSERT_IMPL(lbl, ante, cons, msg)
`define GPR_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

>>> hdl/gpr_pkg.sv
// Types, constants and font ROM for the glyph pixel renderer.
package gpr_pkg;

  localparam logic [7:0] FONT_FIRST = 8'd32;
  localparam logic [7:0] FONT_LAST  = 8'd127;
  localparam int unsigned FONT_GLYPHS = 96;
  localparam int unsigned GLYPH_W = 5;
  localparam int unsigned GLYPH_H = 8;

  // One glyph: five column bytes, column 0 in the low byte, bit 0 is the top row.
  typedef logic [GLYPH_W-1:0][GLYPH_H-1:0] glyph_bits_t;

  // Work descriptor handed from front to back.
  typedef struct packed {
    glyph_bits_t bits;
    logic [7:0]  x;
    logic [7:0]  y;
    logic [15:0] fg;
    logic [15:0] bg;
    logic [2:0]  col_lo;
    logic [2:0]  col_hi;
    logic [2:0]  row_lo;
    logic [2:0]  row_hi;
  } glyph_t;

  localparam logic [39:0] FONT_ROM [FONT_GLYPHS] = '{
    40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14,
    40'h122A7F2A24, 40'h6264081323, 40'h5022554936, 40'h0000030500,
    40'h0041221C00, 40'h001C224100, 40'h082A1C2A08, 40'h08083E0808,
    40'h0000305000, 40'h0808080808, 40'h0000606000, 40'h0204081020,
    40'h3E4549513E, 40'h00407F4200, 40'h4649516142, 40'h314B454121,
    40'h107F121418, 40'h3945454527, 40'h3049494A3C, 40'h0305097101,
    40'h3649494936, 40'h1E29494906, 40'h0000363600, 40'h0000365600,
    40'h4122140800, 40'h1414141414, 40'h0008142241, 40'h0609510102,
    40'h3E41794932, 40'h7E1111117E, 40'h364949497F, 40'h224141413E,
    40'h1C2241417F, 40'h414949497F, 40'h010909097F, 40'h7A4941413E,
    40'h7F0808087F, 40'h00417F4100, 40'h013F414020, 40'h412214087F,
    40'h404040407F, 40'h7F0204027F, 40'h7F1008047F, 40'h3E4141413E,
    40'h060909097F, 40'h5E2151413E, 40'h462919097F, 40'h3149494946,
    40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F, 40'h7F2018207F,
    40'h6314081463, 40'h0304780403, 40'h4345495161, 40'h41417F0000,
    40'h2010080402, 40'h00007F4141, 40'h0402010204, 40'h4040404040,
    40'h0004020100, 40'h7854545420, 40'h384444487F, 40'h2044444438,
    40'h7F48444438, 40'h1854545438, 40'h0201097E08, 40'h3C54541408,
    40'h780404087F, 40'h00407D4400, 40'h003D444020, 40'h4428107F00,
    40'h00407F4100, 40'h780418047C, 40'h780404087C, 40'h3844444438,
    40'h081414147C, 40'h7C18141408, 40'h080404087C, 40'h2054545448,
    40'h2040443F04, 40'h7C2040403C, 40'h1C2040201C, 40'h3C4030403C,
    40'h4428102844, 40'h3C5050500C, 40'h444C546444, 40'h0041360800,
    40'h00007F0000, 40'h0008364100, 40'h081C2A0808, 40'h7F7F7F7F7F
  };

  // Glyph for a code already known to be inside the font.
  function automatic glyph_bits_t glyph_lookup(input logic [7:0] code);
    logic [7:0] idx;
    idx = code - FONT_FIRST;
    return FONT_ROM[idx[6:0]];
  endfunction

endpackage

>>> hdl/gpr_glyph_if.sv
// Input channel: one glyph request per beat.
interface gpr_glyph_if;
  logic               valid;
  logic               ready;
  logic [7:0]         char_code;
  logic signed [10:0] x_pos;
  logic signed [10:0] y_pos;
  logic [15:0]        fg_color;
  logic [15:0]        bg_color;

  modport source (output valid, char_code, x_pos, y_pos, fg_color, bg_color, input ready);
  modport sink   (input valid, char_code, x_pos, y_pos, fg_color, bg_color, output ready);
endinterface

>>> hdl/gpr_pixel_if.sv
// Output channel: one pixel write per beat.
interface gpr_pixel_if;
  logic        valid;
  logic        ready;
  logic [7:0]  pixel_x;
  logic [7:0]  pixel_y;
  logic [15:0] pixel_color;
  logic        last_pixel;

  modport source (output valid, pixel_x, pixel_y, pixel_color, last_pixel, input ready);
  modport sink   (input valid, pixel_x, pixel_y, pixel_color, last_pixel, output ready);
endinterface

>>> hdl/gpr_front.sv
// Front end: accepts glyph requests, clips against the screen, fetches the glyph.
module gpr_front #(
  parameter int LONG_SIDE  = 160,
  parameter int SHORT_SIDE = 128
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             rot_odd_i,
  gpr_glyph_if.sink        glyph_i,
  input  logic             q_ready_i,
  output logic             q_push_o,
  output gpr_pkg::glyph_t  q_data_o
);

  logic               valid_q, valid_d;
  gpr_pkg::glyph_t    desc_q, desc_d;
  logic [10:0]        width, height;
  logic [4:0]         col_vis;
  logic [7:0]         row_vis;
  logic signed [11:0] px [5];
  logic signed [11:0] py [8];
  logic               in_font;
  logic               accept;

  assign width  = rot_odd_i ? 11'(LONG_SIDE)  : 11'(SHORT_SIDE);
  assign height = rot_odd_i ? 11'(SHORT_SIDE) : 11'(LONG_SIDE);

  assign in_font = (glyph_i.char_code >= gpr_pkg::FONT_FIRST) &&
                   (glyph_i.char_code <= gpr_pkg::FONT_LAST);

  assign glyph_i.ready = !valid_q || q_ready_i;
  assign accept        = glyph_i.valid && glyph_i.ready;

  always_comb begin
    for (int c = 0; c < 5; c++) begin
      px[c]      = {glyph_i.x_pos[10], glyph_i.x_pos} + 12'(c);
      col_vis[c] = !px[c][11] && (px[c][10:0] < width);
    end
    for (int r = 0; r < 8; r++) begin
      py[r]      = {glyph_i.y_pos[10], glyph_i.y_pos} + 12'(r);
      row_vis[r] = !py[r][11] && (py[r][10:0] < height);
    end
  end

  always_comb begin
    desc_d        = '0;
    desc_d.bits   = gpr_pkg::glyph_lookup(glyph_i.char_code);
    desc_d.x      = glyph_i.x_pos[7:0];
    desc_d.y      = glyph_i.y_pos[7:0];
    desc_d.fg     = glyph_i.fg_color;
    desc_d.bg     = glyph_i.bg_color;
    // visible span is contiguous; find its ends
    for (int c = 4; c >= 0; c--) if (col_vis[c]) desc_d.col_lo = 3'(c);
    for (int c = 0; c < 5; c++)  if (col_vis[c]) desc_d.col_hi = 3'(c);
    for (int r = 7; r >= 0; r--) if (row_vis[r]) desc_d.row_lo = 3'(r);
    for (int r = 0; r < 8; r++)  if (row_vis[r]) desc_d.row_hi = 3'(r);
  end

  always_comb begin
    valid_d = valid_q && !q_ready_i;
    if (accept) begin
      valid_d = in_font && (|col_vis) && (|row_vis);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      desc_q <= desc_d;
    end
  end

  assign q_push_o = valid_q;
  assign q_data_o = desc_q;

endmodule

>>> hdl/gpr_queue.sv
// Two-entry descriptor queue between front and back.
module gpr_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  gpr_pkg::glyph_t  push_data_i,
  output logic             ready_o,
  output logic             valid_o,
  input  logic             pop_i,
  output gpr_pkg::glyph_t  data_o
);

  gpr_pkg::glyph_t entry_q [2];
  logic            wr_ptr_q, rd_ptr_q;
  logic [1:0]      count_q, count_d;
  logic            do_push, do_pop;

  assign ready_o = (count_q != 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;
  assign data_o  = entry_q[rd_ptr_q];

  always_comb begin
    case ({do_push, do_pop})
      2'b10:   count_d = count_q + 2'd1;
      2'b01:   count_d = count_q - 2'd1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= 2'd0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (do_push) wr_ptr_q <= !wr_ptr_q;
      if (do_pop)  rd_ptr_q <= !rd_ptr_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

>>> hdl/gpr_back.sv
// Back end: walks the visible window of a glyph and emits one pixel per beat.
`include "glyph_pixel_renderer_top_macros.svh"

module gpr_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_valid_i,
  input  gpr_pkg::glyph_t  q_data_i,
  output logic             q_pop_o,
  gpr_pixel_if.source      pixel_o
);

  logic            busy_q;
  gpr_pkg::glyph_t d_q;
  logic [2:0]      row_q, col_q;
  logic            pix_valid_q;
  logic [7:0]      pix_x_q, pix_y_q;
  logic [15:0]     pix_color_q;
  logic            pix_last_q;
  logic            step, last_px, pop;

  assign step    = busy_q && (!pix_valid_q || pixel_o.ready);
  assign last_px = (row_q == d_q.row_hi) && (col_q == d_q.col_hi);
  assign pop     = q_valid_i && (!busy_q || (step && last_px));
  assign q_pop_o = pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      pix_valid_q <= 1'b0;
    end else begin
      if (pop) begin
        busy_q <= 1'b1;
      end else if (step && last_px) begin
        busy_q <= 1'b0;
      end
      if (step) begin
        pix_valid_q <= 1'b1;
      end else if (pixel_o.ready) begin
        pix_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      d_q   <= q_data_i;
      row_q <= q_data_i.row_lo;
      col_q <= q_data_i.col_lo;
    end else if (step) begin
      if (col_q == d_q.col_hi) begin
        col_q <= d_q.col_lo;
        row_q <= row_q + 3'd1;
      end else begin
        col_q <= col_q + 3'd1;
      end
    end
    if (step) begin
      pix_x_q     <= d_q.x + {5'd0, col_q};
      pix_y_q     <= d_q.y + {5'd0, row_q};
      pix_color_q <= d_q.bits[col_q][row_q] ? d_q.fg : d_q.bg;
      pix_last_q  <= last_px;
    end
  end

  assign pixel_o.valid       = pix_valid_q;
  assign pixel_o.pixel_x     = pix_x_q;
  assign pixel_o.pixel_y     = pix_y_q;
  assign pixel_o.pixel_color = pix_color_q;
  assign pixel_o.last_pixel  = pix_last_q;

  `GPR_ASSERT_IMPL(a_row_in_window, busy_q, (row_q >= d_q.row_lo) && (row_q <= d_q.row_hi), "row outside window")
  `GPR_ASSERT_IMPL(a_col_in_window, busy_q, (col_q >= d_q.col_lo) && (col_q <= d_q.col_hi), "col outside window")
  `GPR_ASSERT_NEXT(a_idle_after_last, step && last_px && !pop, !busy_q, "busy after last pixel")

endmodule

>>> hdl/glyph_pixel_renderer_top.sv
// Top level of the 5x8 glyph pixel renderer.
//
// Usage:
//   glyph_i carries one glyph request per beat (code, signed x/y of the
//   top-left corner, foreground and background RGB565). pixel_o carries the
//   glyph's on-screen pixel writes in row-major order; last_pixel marks the
//   final one. Codes outside 32..127 and fully off-screen glyphs give no beats.
//   cfg_we_i/cfg_wdata_i write the rotation register (odd: LONG_SIDE wide by
//   SHORT_SIDE high); write it only while the block is idle.
// Timing:
//   A request reaches pixel_o through the front register, the queue,
//   the walker state and the output register. The walker emits one pixel
//   per cycle while not stalled, at most 40 per glyph; requests are taken
//   back to back while earlier glyphs draw, in a two-deep descriptor queue.
// Reset: rotation returns to 1, queue and pipeline empty.
// Stall: a low pixel_o.ready holds the output register; the walker then the
//   queue then glyph_i.ready back up in turn.
module glyph_pixel_renderer_top #(
  parameter int LONG_SIDE  = 160,
  parameter int SHORT_SIDE = 128
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_wdata_i,
  gpr_glyph_if.sink   glyph_i,
  gpr_pixel_if.source pixel_o
);

  logic [1:0]      rot_q;
  logic            q_push, q_ready, q_valid, q_pop;
  gpr_pkg::glyph_t q_in, q_out;

  // rotation register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rot_q <= 2'd1;
    end else if (cfg_we_i) begin
      rot_q <= cfg_wdata_i;
    end
  end

  // clip, classify and fetch glyph bits
  gpr_front #(
    .LONG_SIDE  (LONG_SIDE),
    .SHORT_SIDE (SHORT_SIDE)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rot_odd_i (rot_q[0]),
    .glyph_i   (glyph_i),
    .q_ready_i (q_ready),
    .q_push_o  (q_push),
    .q_data_o  (q_in)
  );

  // descriptor queue decouples request intake from pixel drawing
  gpr_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_in),
    .ready_o     (q_ready),
    .valid_o     (q_valid),
    .pop_i       (q_pop),
    .data_o      (q_out)
  );

  // pixel walker with registered output
  gpr_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_data_i  (q_out),
    .q_pop_o   (q_pop),
    .pixel_o   (pixel_o)
  );

endmodule
